@@ design/rmv_pkg.sv @@
// ----------------------------------------------------------------------------
// rmv_pkg
// Shared constants for the running mean and variance block.
// ----------------------------------------------------------------------------
`default_nettype none

package rmv_pkg;

    localparam int MAX_SAMPLES_DEF = 1024;

    localparam int SAMPLE_W  = 16;
    localparam int FRAC_W    = 16;
    localparam int MEAN_W    = 32;
    localparam int DELTA_W   = 34;
    localparam int MAG_W     = 33;
    localparam int DVD_W     = 64;
    localparam int M2_W      = 64;
    localparam int VAR_W     = 46;
    localparam int CNT_OUT_W = 11;

    localparam int SAMPLE_ITERS = MAG_W;
    localparam int FINAL_ITERS  = DVD_W;
    localparam int ITER_W       = $clog2(FINAL_ITERS + 1);

endpackage

`default_nettype wire

@@ design/running_mean_variance.sv @@
// ----------------------------------------------------------------------------
// running_mean_variance
// Welford one-pass mean and population variance over a set of Q8.8 samples.
// ----------------------------------------------------------------------------
// Input channel (in_valid / in_stall) carries sample and last. One transaction
// is taken at a time; in_stall is high while a sample is being folded in.
// Each taken sample runs a bit-serial restoring divide of |x - mean| by the
// running count, a mean update step, a setup step, a shift-add multiply of
// the two deviations and an accumulate step; the next sample is taken only
// once the accumulate step is done. A sample arriving with the set full is
// dropped, setting the overflow flag.
// A transaction with last set closes the set: after the sample step (or
// directly, if the sample was dropped), M2 is divided by the count in the same
// serial divider, and the result is then loaded into the output register.
// The result sits in an output register (out_valid / out_stall); the next set
// starts while it waits. A closing set that finishes while the previous result
// is still stalled holds, with in_stall high, until that result is taken.
// Reset (rst_n low, asynchronous) clears count, mean, M2, the overflow flag and
// out_valid; all but out_valid are cleared again when each result is loaded.
// ----------------------------------------------------------------------------
`default_nettype none

module running_mean_variance #(
    parameter int MAX_SAMPLES = rmv_pkg::MAX_SAMPLES_DEF
) (
    input  wire logic                                 clk,
    input  wire logic                                 rst_n,

    input  wire logic                                 in_valid,
    output logic                                      in_stall,
    input  wire logic signed [rmv_pkg::SAMPLE_W-1:0]  sample,
    input  wire logic                                 last,

    output logic                                      out_valid,
    input  wire logic                                 out_stall,
    output logic signed [rmv_pkg::MEAN_W-1:0]         mean_value,
    output logic        [rmv_pkg::VAR_W-1:0]          variance_value,
    output logic        [rmv_pkg::CNT_OUT_W-1:0]      sample_count,
    output logic                                      overflowed
);

    localparam int CW       = $clog2(MAX_SAMPLES + 1);
    localparam int SAMPLE_W = rmv_pkg::SAMPLE_W;
    localparam int FRAC_W   = rmv_pkg::FRAC_W;
    localparam int MEAN_W   = rmv_pkg::MEAN_W;
    localparam int DELTA_W  = rmv_pkg::DELTA_W;
    localparam int MAG_W    = rmv_pkg::MAG_W;
    localparam int DVD_W    = rmv_pkg::DVD_W;
    localparam int M2_W     = rmv_pkg::M2_W;
    localparam int VAR_W    = rmv_pkg::VAR_W;
    localparam int CNT_OUT_W = rmv_pkg::CNT_OUT_W;
    localparam int ITER_W   = rmv_pkg::ITER_W;

    typedef enum logic [2:0] {
        S_IDLE,
        S_DIV,
        S_MEAN,
        S_SETUP,
        S_MUL,
        S_ACCUM,
        S_FINAL
    } state_t;

    state_t                    state_reg;
    logic [CW-1:0]             count_reg;
    logic signed [MEAN_W-1:0]  mean_reg;
    logic [M2_W-1:0]           m2_reg;
    logic                      overflow_reg;

    logic signed [SAMPLE_W-1:0] sample_reg;
    logic                      last_reg;
    logic                      neg_reg;
    logic                      final_reg;

    logic [DVD_W-1:0]          dvd_reg;
    logic [DVD_W-1:0]          quo_reg;
    logic [CW-1:0]             rem_reg;
    logic [CW-1:0]             divisor_reg;
    logic [ITER_W-1:0]         iter_reg;

    logic [MAG_W-1:0]          mag1_reg;
    logic [MAG_W-1:0]          mplier_reg;
    logic [M2_W-1:0]           mcand_reg;
    logic [M2_W-1:0]           acc_reg;

    logic                      out_valid_reg;
    logic signed [MEAN_W-1:0]  mean_out_reg;
    logic [VAR_W-1:0]          var_out_reg;
    logic [CNT_OUT_W-1:0]      cnt_out_reg;
    logic                      ovf_out_reg;

    logic                      in_take;
    logic                      out_take;
    logic                      set_full;
    logic signed [DELTA_W-1:0] x_in;
    logic signed [DELTA_W-1:0] x_held;
    logic signed [DELTA_W-1:0] mean_ext;
    logic signed [DELTA_W-1:0] delta_in;
    logic signed [DELTA_W-1:0] delta_held;
    logic [DELTA_W-1:0]        mag_in;
    logic [DELTA_W-1:0]        mag_held;
    logic [CW:0]               rem_shift;
    logic                      div_ge;
    logic [CW:0]               rem_sub;
    logic [DELTA_W-1:0]        quo_ext;
    logic [DELTA_W-1:0]        mean_upd;
    logic [M2_W:0]             m2_sum;
    logic [M2_W-1:0]           m2_sat;
    logic [VAR_W-1:0]          var_sat;
    logic [CW+CNT_OUT_W-1:0]   cnt_wide;

    always_comb
    begin
        in_take   = in_valid && !in_stall;
        out_take  = out_valid_reg && !out_stall;
        set_full  = (count_reg == CW'(MAX_SAMPLES));

        x_in      = {{(DELTA_W-SAMPLE_W-FRAC_W){sample[SAMPLE_W-1]}}, sample, FRAC_W'(0)};
        x_held    = {{(DELTA_W-SAMPLE_W-FRAC_W){sample_reg[SAMPLE_W-1]}}, sample_reg,
                     FRAC_W'(0)};
        mean_ext  = {{(DELTA_W-MEAN_W){mean_reg[MEAN_W-1]}}, mean_reg};
        delta_in  = x_in - mean_ext;
        delta_held = x_held - mean_ext;
        mag_in    = delta_in[DELTA_W-1] ? (DELTA_W'(0) - delta_in) : delta_in;
        mag_held  = delta_held[DELTA_W-1] ? (DELTA_W'(0) - delta_held) : delta_held;

        rem_shift = {rem_reg, dvd_reg[DVD_W-1]};
        div_ge    = (rem_shift >= {1'b0, divisor_reg});
        rem_sub   = rem_shift - {1'b0, divisor_reg};

        quo_ext   = {{(DELTA_W-MAG_W){1'b0}}, quo_reg[MAG_W-1:0]};
        mean_upd  = neg_reg ? (mean_ext - quo_ext) : (mean_ext + quo_ext);

        m2_sum    = {1'b0, m2_reg} + {{(FRAC_W+1){1'b0}}, acc_reg[M2_W-1:FRAC_W]};
        m2_sat    = m2_sum[M2_W] ? {M2_W{1'b1}} : m2_sum[M2_W-1:0];

        if (count_reg == CW'(0))
        begin
            var_sat = VAR_W'(0);
        end
        else if (quo_reg[DVD_W-1:VAR_W] != '0)
        begin
            var_sat = {VAR_W{1'b1}};
        end
        else
        begin
            var_sat = quo_reg[VAR_W-1:0];
        end

        cnt_wide  = {{CNT_OUT_W{1'b0}}, count_reg};
    end

    assign in_stall       = (state_reg != S_IDLE);
    assign out_valid      = out_valid_reg;
    assign mean_value     = mean_out_reg;
    assign variance_value = var_out_reg;
    assign sample_count   = cnt_out_reg;
    assign overflowed     = ovf_out_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            count_reg     <= '0;
            mean_reg      <= '0;
            m2_reg        <= '0;
            overflow_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            // in the closing step the output register is reloaded instead
            if (out_take && state_reg != S_FINAL)
            begin
                out_valid_reg <= 1'b0;
            end

            case (state_reg)
                S_IDLE:
                begin
                    if (in_take)
                    begin
                        sample_reg <= sample;
                        last_reg   <= last;
                        if (set_full)
                        begin
                            overflow_reg <= 1'b1;
                            if (last)
                            begin
                                final_reg   <= 1'b1;
                                dvd_reg     <= m2_reg;
                                divisor_reg <= count_reg;
                                rem_reg     <= '0;
                                iter_reg    <= ITER_W'(rmv_pkg::FINAL_ITERS);
                                state_reg   <= S_DIV;
                            end
                        end
                        else
                        begin
                            final_reg   <= 1'b0;
                            neg_reg     <= delta_in[DELTA_W-1];
                            mag1_reg    <= mag_in[MAG_W-1:0];
                            dvd_reg     <= {mag_in[MAG_W-1:0], (DVD_W-MAG_W)'(0)};
                            divisor_reg <= count_reg + CW'(1);
                            rem_reg     <= '0;
                            iter_reg    <= ITER_W'(rmv_pkg::SAMPLE_ITERS);
                            state_reg   <= S_DIV;
                        end
                    end
                end

                S_DIV:
                begin
                    rem_reg  <= div_ge ? rem_sub[CW-1:0] : rem_shift[CW-1:0];
                    quo_reg  <= {quo_reg[DVD_W-2:0], div_ge};
                    dvd_reg  <= {dvd_reg[DVD_W-2:0], 1'b0};
                    iter_reg <= iter_reg - ITER_W'(1);
                    if (iter_reg == ITER_W'(1))
                    begin
                        state_reg <= final_reg ? S_FINAL : S_MEAN;
                    end
                end

                S_MEAN:
                begin
                    mean_reg  <= mean_upd[MEAN_W-1:0];
                    count_reg <= divisor_reg;
                    state_reg <= S_SETUP;
                end

                S_SETUP:
                begin
                    mplier_reg <= mag_held[MAG_W-1:0];
                    mcand_reg  <= {{(M2_W-MAG_W){1'b0}}, mag1_reg};
                    acc_reg    <= '0;
                    iter_reg   <= ITER_W'(rmv_pkg::SAMPLE_ITERS);
                    state_reg  <= S_MUL;
                end

                S_MUL:
                begin
                    if (mplier_reg[0])
                    begin
                        acc_reg <= acc_reg + mcand_reg;
                    end
                    mcand_reg  <= {mcand_reg[M2_W-2:0], 1'b0};
                    mplier_reg <= {1'b0, mplier_reg[MAG_W-1:1]};
                    iter_reg   <= iter_reg - ITER_W'(1);
                    if (iter_reg == ITER_W'(1))
                    begin
                        state_reg <= S_ACCUM;
                    end
                end

                S_ACCUM:
                begin
                    m2_reg <= m2_sat;
                    if (last_reg)
                    begin
                        final_reg   <= 1'b1;
                        dvd_reg     <= m2_sat;
                        divisor_reg <= count_reg;
                        rem_reg     <= '0;
                        iter_reg    <= ITER_W'(rmv_pkg::FINAL_ITERS);
                        state_reg   <= S_DIV;
                    end
                    else
                    begin
                        state_reg <= S_IDLE;
                    end
                end

                S_FINAL:
                begin
                    if (!out_valid_reg || !out_stall)
                    begin
                        out_valid_reg <= 1'b1;
                        mean_out_reg  <= mean_reg;
                        var_out_reg   <= var_sat;
                        cnt_out_reg   <= cnt_wide[CNT_OUT_W-1:0];
                        ovf_out_reg   <= overflow_reg;
                        count_reg     <= '0;
                        mean_reg      <= '0;
                        m2_reg        <= '0;
                        overflow_reg  <= 1'b0;
                        state_reg     <= S_IDLE;
                    end
                end

                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CW'(MAX_SAMPLES))
        else $error("sample count beyond the set bound");

    a_overflow_full: assert property (@(posedge clk) disable iff (!rst_n)
        overflow_reg |-> set_full)
        else $error("overflow flag set while the set is not full");

    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && out_stall |=> out_valid_reg && $stable(var_out_reg))
        else $error("stalled result transaction changed");

    a_out_source: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid_reg) |-> $past(state_reg) == S_FINAL)
        else $error("result raised outside the closing step");

    a_final_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == S_FINAL |-> count_reg != CW'(0))
        else $error("set closed with no samples");

endmodule

`default_nettype wire
